[src/bfa_pkg.sv]
// Shared types and constants for the bitmap frame allocator.
package bfa_pkg;

    localparam int WORD_BITS = 32;
    localparam int FIDX_W    = 21;

    localparam logic [31:0] BASE_ADDR = 32'h4000_0000;
    localparam logic [19:0] BASE_PAGE = 20'h40000;
    localparam logic [31:0] PAGE_MASK = 32'h0000_0FFF;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [FIDX_W-1:0]    frame_idx_t;

    typedef enum logic [1:0] {
        CMD_INIT    = 2'd0,
        CMD_ALLOC   = 2'd1,
        CMD_FREE    = 2'd2,
        CMD_RESERVE = 2'd3
    } cmd_t;

    typedef struct packed {
        logic       hit;
        frame_idx_t frame;
    } scan_hit_t;

endpackage

[src/bitmap_frame_allocator.sv]
// Bitmap page-frame allocator (first fit) over a RAM region of 4 KB frames at 0x40000000.
//
// The used-frame bitmap lives in a RAM of 32-bit words (FRAMES/32 words, rounded up).
// Init, free and reserve sweep the bitmap one word per cycle through a read-modify-write
// pipeline. An allocate first makes a search sweep at the same rate, then, if a run
// was found, a marking sweep; a zero or oversized allocate goes straight to its
// result. After reset the block sweeps the bitmap once to establish frame 0 as used,
// holding in_ready low meanwhile; kernel_pages writes are taken at any time. One item
// is in flight at a time; the next item is taken while its predecessor's result
// waits on the output.
module bitmap_frame_allocator #(
    parameter int FRAMES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [31:0] addr,
    input  logic [31:0] end_addr,
    input  logic [12:0] count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_addr,
    output logic        failed,
    output logic [12:0] free_frames,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] kernel_pages
);
    import bfa_pkg::*;

    localparam int WORDS = (FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int UW    = $clog2(FRAMES + 1);
    localparam int CW0   = $clog2(FRAMES + 64);
    localparam int CW    = (CW0 > 14) ? CW0 : 14;
    localparam logic [AW:0] WORDS_C  = (AW + 1)'(WORDS);
    localparam frame_idx_t  FRAMES_F = frame_idx_t'(FRAMES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RMW,
        S_DONE
    } state_t;

    state_t        state_reg, state_next;
    cmd_t          op_reg, op_next;
    logic          boot_reg, boot_next;
    logic [AW:0]   rd_ptr_reg, rd_ptr_next;
    logic          rd_vld_reg, rd_vld_next;
    logic [AW-1:0] rd_word_reg, rd_word_next;
    frame_idx_t    lo_a_reg, lo_a_next;
    frame_idx_t    hi_a_reg, hi_a_next;
    frame_idx_t    lo_b_reg, lo_b_next;
    frame_idx_t    hi_b_reg, hi_b_next;
    logic [CW-1:0] need_reg, need_next;
    logic          found_reg, found_next;
    frame_idx_t    hit_frame_reg, hit_frame_next;
    word_t         dmask_reg, dmask_next;
    logic          dvld_reg, dvld_next;
    logic          dsub_reg, dsub_next;
    logic [UW-1:0] used_reg, used_next;
    logic [12:0]   kf_reg, kf_next;
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   res_addr_reg, res_addr_next;
    logic          failed_reg, failed_next;
    logic [12:0]   free_reg, free_next;

    logic          rd_issue;
    logic          pass_done;
    logic          scan_clear;
    logic          ram_we;
    word_t         rdata;
    word_t         new_word;
    word_t         old_word;
    word_t         vmask;
    word_t         rmask;
    logic [15:0]   wd_idx;
    logic [5:0]    pc;
    scan_hit_t     hit;
    logic [19:0]   f0;
    logic [20:0]   f_end;
    logic [19:0]   s_page;
    logic [31:0]   t_end;
    logic [31:0]   free_w;

    function automatic word_t range_mask(frame_idx_t lo, frame_idx_t hi, logic [15:0] w);
        logic [15:0] lw;
        logic [15:0] hw;
        word_t       ml;
        word_t       mh;
        lw = lo[20:5];
        hw = hi[20:5];
        if (w < lw)
        begin
            ml = '0;
        end
        else if (w == lw)
        begin
            ml = word_t'('1) << lo[4:0];
        end
        else
        begin
            ml = '1;
        end
        if (w < hw)
        begin
            mh = '1;
        end
        else if (w == hw)
        begin
            mh = ~(word_t'('1) << hi[4:0]);
        end
        else
        begin
            mh = '0;
        end
        return ml & mh;
    endfunction

    function automatic logic [5:0] popcount(word_t v);
        logic [5:0] s;
        s = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            s = s + 6'(v[i]);
        end
        return s;
    endfunction

    assign rd_issue  = ((state_reg == S_SCAN) || (state_reg == S_RMW)) && (rd_ptr_reg != WORDS_C);
    assign pass_done = (rd_ptr_reg == WORDS_C) && !rd_vld_reg;
    assign wd_idx    = 16'(rd_word_reg);
    assign vmask     = range_mask('0, FRAMES_F, wd_idx);
    assign rmask     = (range_mask(lo_a_reg, hi_a_reg, wd_idx)
                     | range_mask(lo_b_reg, hi_b_reg, wd_idx)) & vmask;
    assign old_word  = (op_reg == CMD_INIT) ? '0 : rdata;
    assign ram_we    = (state_reg == S_RMW) && rd_vld_reg;
    assign pc        = popcount(dmask_reg);

    always_comb
    begin
        if (op_reg == CMD_INIT)
        begin
            new_word = rmask;
        end
        else if (op_reg == CMD_FREE)
        begin
            new_word = rdata & ~rmask;
        end
        else
        begin
            new_word = rdata | rmask;
        end
    end

    bfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS),
        .AW    (AW)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (rd_word_reg),
        .wdata (new_word),
        .re    (rd_issue),
        .raddr (rd_ptr_reg[AW-1:0]),
        .rdata (rdata)
    );

    bfa_scan #(
        .CW (CW)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (scan_clear),
        .word_vld ((state_reg == S_SCAN) && rd_vld_reg),
        .word_idx (wd_idx),
        .used     (rdata | ~vmask),
        .need     (need_reg),
        .hit      (hit)
    );

    assign f0     = addr[31:12] - BASE_PAGE;
    assign f_end  = {1'b0, f0} + 21'(count);
    assign s_page = (addr < BASE_ADDR) ? BASE_PAGE : addr[31:12];
    assign t_end  = end_addr - BASE_ADDR + PAGE_MASK;
    assign free_w = 32'(FRAMES) - 32'(used_reg);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        boot_next      = boot_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_vld_next    = rd_issue;
        rd_word_next   = rd_word_reg;
        lo_a_next      = lo_a_reg;
        hi_a_next      = hi_a_reg;
        lo_b_next      = lo_b_reg;
        hi_b_next      = hi_b_reg;
        need_next      = need_reg;
        found_next     = found_reg;
        hit_frame_next = hit_frame_reg;
        dmask_next     = new_word ^ old_word;
        dvld_next      = ram_we;
        dsub_next      = dsub_reg;
        used_next      = used_reg;
        kf_next        = kf_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_addr_next  = res_addr_reg;
        failed_next    = failed_reg;
        free_next      = free_reg;
        scan_clear     = 1'b0;

        if (cfg_valid)
        begin
            kf_next = kernel_pages;
        end

        if (dvld_reg)
        begin
            if (dsub_reg)
            begin
                used_next = used_reg - UW'(pc);
            end
            else
            begin
                used_next = used_reg + UW'(pc);
            end
        end

        if (rd_issue)
        begin
            rd_ptr_next  = rd_ptr_reg + (AW + 1)'(1);
            rd_word_next = rd_ptr_reg[AW-1:0];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = cmd_t'(cmd);
                    rd_ptr_next = '0;
                    lo_b_next   = '0;
                    hi_b_next   = '0;
                    dsub_next   = 1'b0;
                    found_next  = 1'b0;
                    unique case (cmd_t'(cmd))
                        CMD_INIT:
                        begin
                            lo_a_next  = '0;
                            hi_a_next  = (kf_reg == 13'd0) ? frame_idx_t'(1)
                                                           : frame_idx_t'(kf_reg);
                            used_next  = '0;
                            state_next = S_RMW;
                        end
                        CMD_ALLOC:
                        begin
                            need_next = CW'(count);
                            if ((count == 13'd0) || (frame_idx_t'(count) > FRAMES_F))
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                scan_clear = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        CMD_FREE:
                        begin
                            dsub_next = 1'b1;
                            lo_a_next = {1'b0, f0};
                            if (f_end[20])
                            begin
                                hi_a_next = frame_idx_t'(21'h10_0000);
                                hi_b_next = {1'b0, f_end[19:0]};
                            end
                            else
                            begin
                                hi_a_next = f_end;
                            end
                            state_next = S_RMW;
                        end
                        CMD_RESERVE:
                        begin
                            lo_a_next  = {1'b0, s_page - BASE_PAGE};
                            hi_a_next  = {1'b0, t_end[31:12]};
                            state_next = S_RMW;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (hit.hit && !found_reg)
                begin
                    found_next     = 1'b1;
                    hit_frame_next = hit.frame;
                end
                if (pass_done)
                begin
                    if (found_reg)
                    begin
                        lo_a_next   = hit_frame_reg;
                        hi_a_next   = hit_frame_reg + frame_idx_t'(need_reg);
                        rd_ptr_next = '0;
                        state_next  = S_RMW;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_RMW:
            begin
                if (pass_done)
                begin
                    if (boot_reg)
                    begin
                        boot_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if ((op_reg == CMD_ALLOC) && found_reg)
                    begin
                        res_addr_next = BASE_ADDR + {hit_frame_reg[19:0], 12'b0};
                    end
                    else
                    begin
                        res_addr_next = '0;
                    end
                    failed_next = (op_reg == CMD_ALLOC) && !found_reg;
                    free_next   = free_w[12:0];
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RMW;
            op_reg        <= CMD_INIT;
            boot_reg      <= 1'b1;
            rd_ptr_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            rd_word_reg   <= '0;
            lo_a_reg      <= '0;
            hi_a_reg      <= frame_idx_t'(1);
            lo_b_reg      <= '0;
            hi_b_reg      <= '0;
            need_reg      <= '0;
            found_reg     <= 1'b0;
            hit_frame_reg <= '0;
            dmask_reg     <= '0;
            dvld_reg      <= 1'b0;
            dsub_reg      <= 1'b0;
            used_reg      <= '0;
            kf_reg        <= '0;
            out_valid_reg <= 1'b0;
            res_addr_reg  <= '0;
            failed_reg    <= 1'b0;
            free_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            boot_reg      <= boot_next;
            rd_ptr_reg    <= rd_ptr_next;
            rd_vld_reg    <= rd_vld_next;
            rd_word_reg   <= rd_word_next;
            lo_a_reg      <= lo_a_next;
            hi_a_reg      <= hi_a_next;
            lo_b_reg      <= lo_b_next;
            hi_b_reg      <= hi_b_next;
            need_reg      <= need_next;
            found_reg     <= found_next;
            hit_frame_reg <= hit_frame_next;
            dmask_reg     <= dmask_next;
            dvld_reg      <= dvld_next;
            dsub_reg      <= dsub_next;
            used_reg      <= used_next;
            kf_reg        <= kf_next;
            out_valid_reg <= out_valid_next;
            res_addr_reg  <= res_addr_next;
            failed_reg    <= failed_next;
            free_reg      <= free_next;
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign result_addr = res_addr_reg;
    assign failed      = failed_reg;
    assign free_frames = free_reg;

endmodule

[src/bfa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/bfa_scan.sv]
// First-fit run finder: one bitmap word per cycle, free-run length carried across words.
module bfa_scan #(
    parameter int CW = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  logic               word_vld,
    input  logic [15:0]        word_idx,
    input  bfa_pkg::word_t     used,
    input  logic [CW-1:0]      need,
    output bfa_pkg::scan_hit_t hit
);
    import bfa_pkg::*;

    logic [CW-1:0] carry_reg;
    logic [CW-1:0] carry_next;
    logic [5:0]    lu [6][WORD_BITS];
    logic [CW-1:0] run_end [WORD_BITS];
    word_t         ok;
    logic [4:0]    pos;
    logic          any;

    // lu holds (position + 1) of the last used bit at or below each bit, 0 if none
    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            lu[0][j] = used[j] ? 6'(j + 1) : 6'd0;
        end
        for (int r = 0; r < 5; r++)
        begin
            for (int j = 0; j < WORD_BITS; j++)
            begin
                lu[r+1][j] = lu[r][j];
                if (j >= (1 << r))
                begin
                    if (lu[r][j] == 6'd0)
                    begin
                        lu[r+1][j] = lu[r][j - (1 << r)];
                    end
                end
            end
        end
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (lu[5][j] == 6'd0)
            begin
                run_end[j] = carry_reg + CW'(j + 1);
            end
            else
            begin
                run_end[j] = CW'(j + 1) - CW'(lu[5][j]);
            end
            ok[j] = (run_end[j] >= need);
        end
        any = 1'b0;
        pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (ok[j])
            begin
                any = 1'b1;
                pos = 5'(j);
            end
        end
        carry_next = carry_reg;
        if (clear)
        begin
            carry_next = '0;
        end
        else if (word_vld)
        begin
            carry_next = run_end[WORD_BITS-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
        end
        else
        begin
            carry_reg <= carry_next;
        end
    end

    assign hit.hit   = word_vld && any;
    assign hit.frame = frame_idx_t'({word_idx, 5'b0}) + frame_idx_t'(pos)
                     + frame_idx_t'(1) - frame_idx_t'(need);

endmodule
